// File: rtl/core/imc_pkg.sv
// Shared types and constants for the image moment centroid block.
// No dependencies; every other file in rtl/core imports this package.
package imc_pkg;

	// Fixed field and sum widths
	localparam int WIDTH_W     = 13;
	localparam int PIX_PORT_W  = 16;
	localparam int MASS_W      = 40;
	localparam int MOM_W       = 52;
	localparam int COORD_W     = 20;
	localparam int STEP_W      = $clog2(COORD_W);

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

	// Frame totals queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [MASS_W-1:0] mass;
		logic [MOM_W-1:0]  row_mom;
		logic [MOM_W-1:0]  col_mom;
	} moments_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_DIV,
		BK_PUBLISH
	} back_state_t;

endpackage

// File: rtl/core/imc_fifo.sv
// Small queue of finished frame totals between the accumulator and the divider.
// Depends on imc_pkg for moments_t and the queue depth.
module imc_fifo import imc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  moments_t          wr_data,
	input  logic              rd_en,
	output moments_t          rd_data,
	output logic              q_empty,
	output logic [QCNT_W-1:0] q_count
);

	moments_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_rd;

	assign do_rd   = rd_en && (count_q != '0);
	assign q_empty = (count_q == '0);
	assign q_count = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	// Store an entry on each write beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/imc_front.sv
// Pixel front end: raster position counters, weight products and moment sums.
// Depends on imc_pkg; hands each frame's totals to imc_fifo.
module imc_front import imc_pkg::*; #(
	parameter int MAX_DIM    = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_beat,
	input  logic [PIX_PORT_W-1:0] pixel_value,
	input  logic                  frame_end,
	input  logic [WIDTH_W-1:0]    image_width,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  full,
	output logic                  tot_push,
	output moments_t              tot_data
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int PW    = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;
	localparam int CW    = (CNT_W + 1 > WIDTH_W) ? CNT_W + 1 : WIDTH_W;
	localparam int PRD_W = CNT_W + PW;
	localparam int PND_W = QCNT_W + 1;

	logic [CNT_W-1:0] col_q, row_q;
	logic [CW-1:0]    width_eff;
	logic             col_wrap, row_wrap;

	logic             valid_s1, last_s1;
	logic [PW-1:0]    pix_s1;
	logic [CNT_W-1:0] row_s1, col_s1;

	logic             valid_s2, last_s2;
	logic [PW-1:0]    pix_s2;
	logic [PRD_W-1:0] rowp_s2, colp_s2;

	logic [MASS_W-1:0] mass_q, mass_nx;
	logic [MOM_W-1:0]  rowm_q, rowm_nx, colm_q, colm_nx;
	logic [PND_W-1:0]  pending;

	// Clamp the row width to 1..MAX_DIM
	always_comb begin
		if (image_width == '0) begin
			width_eff = CW'(1);
		end else if (CW'(image_width) > CW'(MAX_DIM)) begin
			width_eff = CW'(MAX_DIM);
		end else begin
			width_eff = CW'(image_width);
		end
	end

	assign col_wrap = (CW'(col_q) + CW'(1)) >= width_eff;
	assign row_wrap = (CW'(row_q) + CW'(1)) >= CW'(MAX_DIM);

	// Hold off new pixels while queued and in-flight frame ends could fill the queue
	assign pending = PND_W'(q_count) + PND_W'(last_s1) + PND_W'(last_s2);
	assign full    = pending >= PND_W'(QDEPTH);

	// Advance the raster position on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_beat) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage valid and frame-end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= in_beat;
			last_s1  <= in_beat && frame_end;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	// Capture the pixel with its position, then form the weighted products
	always_ff @(posedge clk) begin
		pix_s1  <= pixel_value[PW-1:0];
		row_s1  <= row_q;
		col_s1  <= col_q;
		pix_s2  <= pix_s1;
		rowp_s2 <= PRD_W'(row_s1) * PRD_W'(pix_s1);
		colp_s2 <= PRD_W'(col_s1) * PRD_W'(pix_s1);
	end

	assign mass_nx = mass_q + MASS_W'(pix_s2);
	assign rowm_nx = rowm_q + MOM_W'(rowp_s2);
	assign colm_nx = colm_q + MOM_W'(colp_s2);

	// Accumulate; on frame end hand off the totals and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
			rowm_q <= '0;
			colm_q <= '0;
		end else if (valid_s2) begin
			if (last_s2) begin
				mass_q <= '0;
				rowm_q <= '0;
				colm_q <= '0;
			end else begin
				mass_q <= mass_nx;
				rowm_q <= rowm_nx;
				colm_q <= colm_nx;
			end
		end
	end

	assign tot_push         = valid_s2 && last_s2;
	assign tot_data.mass    = mass_nx;
	assign tot_data.row_mom = rowm_nx;
	assign tot_data.col_mom = colm_nx;

endmodule

// File: rtl/core/imc_back.sv
// Back end: shared restoring divider that turns frame totals into centroids,
// and the result register. Depends on imc_pkg; reads frame totals from imc_fifo.
module imc_back import imc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  moments_t           q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [COORD_W-1:0] centroid_x,
	output logic [COORD_W-1:0] centroid_y,
	output logic               no_mass
);

	localparam int NF_W  = MOM_W + FRAC_BITS;
	localparam int HI_W  = NF_W - COORD_W;
	localparam int CMP_W = (HI_W > MASS_W) ? HI_W : MASS_W;

	back_state_t state_q, state_d;

	logic [MASS_W-1:0]  den_q;
	logic [MOM_W-1:0]   rowm_q, colm_q;
	logic               sel_q;
	logic [MASS_W-1:0]  rem_q;
	logic [COORD_W-1:0] shf_q;
	logic [STEP_W-1:0]  step_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic               zero_q;

	logic               ovalid_q;
	logic [COORD_W-1:0] ox_q, oy_q;
	logic               onm_q;

	logic [MOM_W-1:0]   num;
	logic [NF_W-1:0]    n_full;
	logic [HI_W-1:0]    hi;
	logic               ovf;
	logic [MASS_W:0]    trial, diff;
	logic               ge;
	logic               last_step;
	logic               out_free;
	logic [COORD_W-1:0] quot;

	// Scaled dividend: quotient is floor(num * 2^FRAC_BITS / den)
	assign num    = sel_q ? rowm_q : colm_q;
	assign n_full = NF_W'(num) << FRAC_BITS;
	assign hi     = n_full[NF_W-1:COORD_W];
	assign ovf    = CMP_W'(hi) >= CMP_W'(den_q);

	// One restoring step per cycle
	assign trial     = {rem_q, shf_q[COORD_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign diff      = trial - {1'b0, den_q};
	assign quot      = {shf_q[COORD_W-2:0], ge};
	assign last_step = (step_q == STEP_W'(COORD_W - 1));
	assign out_free  = !ovalid_q || pop;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and queue pop
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_data.mass == '0) ? BK_PUBLISH : BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (ovf) begin
					state_d = sel_q ? BK_PUBLISH : BK_CHECK;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (last_step) begin
					state_d = sel_q ? BK_PUBLISH : BK_CHECK;
				end
			end
			BK_PUBLISH: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					den_q  <= q_data.mass;
					rowm_q <= q_data.row_mom;
					colm_q <= q_data.col_mom;
					sel_q  <= 1'b0;
					zero_q <= (q_data.mass == '0);
					x_q    <= '0;
					y_q    <= '0;
				end
			end
			BK_CHECK: begin
				if (ovf) begin
					// saturate a quotient that does not fit the result field
					if (sel_q) begin
						y_q <= '1;
					end else begin
						x_q <= '1;
					end
					sel_q <= 1'b1;
				end else begin
					rem_q  <= MASS_W'(hi);
					shf_q  <= n_full[COORD_W-1:0];
					step_q <= '0;
				end
			end
			BK_DIV: begin
				rem_q  <= ge ? diff[MASS_W-1:0] : trial[MASS_W-1:0];
				shf_q  <= quot;
				step_q <= step_q + 1'b1;
				if (last_step) begin
					if (sel_q) begin
						y_q <= quot;
					end else begin
						x_q <= quot;
					end
					sel_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register valid: set on publish, drop on pop beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == BK_PUBLISH && out_free) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (state_q == BK_PUBLISH && out_free) begin
			ox_q  <= x_q;
			oy_q  <= y_q;
			onm_q <= zero_q;
		end
	end

	assign empty      = !ovalid_q;
	assign centroid_x = ox_q;
	assign centroid_y = oy_q;
	assign no_mass    = onm_q;

endmodule

// File: rtl/core/image_moment_centroid.sv
// Channel   | Handshake              | Payload
// pixels    | push / full            | pixel_value[15:0], frame_end
// centroids | pop / empty            | centroid_x[19:0], centroid_y[19:0], no_mass
// config    | cfg_valid / cfg_ready  | cfg_data[12:0] (image_width)
//
// Pixels are taken one per cycle while full is low; the front pipeline registers
// the pixel and position, then the weighted products, then the sums. For each frame
// end the shared divider finds x, then y, before the result reaches the output register.
// Up to four finished frames wait between the accumulator and the divider;
// full rises while that queue, counting frame ends still in flight, is full.
// Reset clears the sums, counters and queues and sets image_width to 640.
// Top level: depends on imc_pkg, imc_front, imc_fifo and imc_back.
module image_moment_centroid import imc_pkg::*; #(
	parameter int MAX_DIM    = 4096,
	parameter int PIXEL_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [PIX_PORT_W-1:0] pixel_value,
	input  logic                  frame_end,
	output logic                  empty,
	input  logic                  pop,
	output logic [COORD_W-1:0]    centroid_x,
	output logic [COORD_W-1:0]    centroid_y,
	output logic                  no_mass,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIDTH_W-1:0]    cfg_data
);

	logic [WIDTH_W-1:0] width_q;
	logic               in_beat;
	logic               tot_push;
	moments_t           tot_data;
	logic               q_pop;
	moments_t           q_data;
	logic               q_empty;
	logic [QCNT_W-1:0]  q_count;

	assign cfg_ready = 1'b1;
	assign in_beat   = push && !full;

	// Row width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= cfg_data;
		end
	end

	imc_front #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_beat     (in_beat),
		.pixel_value (pixel_value),
		.frame_end   (frame_end),
		.image_width (width_q),
		.q_count     (q_count),
		.full        (full),
		.tot_push    (tot_push),
		.tot_data    (tot_data)
	);

	imc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tot_push),
		.wr_data (tot_data),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_empty (q_empty),
		.q_count (q_count)
	);

	imc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.no_mass    (no_mass)
	);

endmodule

// File: rtl/core/imc_checker.sv
// Port-level checks for image_moment_centroid, attached by bind.
// Depends on imc_pkg for the result field width.
module imc_checker import imc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [COORD_W-1:0] centroid_x,
	input logic [COORD_W-1:0] centroid_y,
	input logic               no_mass
);

	// A massless frame reports zero coordinates
	a_no_mass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_mass) |-> (centroid_x == '0 && centroid_y == '0))
		else $error("no_mass result with nonzero centroid");

	// A waiting result holds until its pop beat
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(centroid_x) && $stable(centroid_y)
			&& $stable(no_mass)))
		else $error("result changed or vanished before pop");

	// Reset leaves no result behind
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result present after reset");

endmodule

bind image_moment_centroid imc_checker u_imc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.centroid_x (centroid_x),
	.centroid_y (centroid_y),
	.no_mass    (no_mass)
);
